/* hdl/mtfd_pkg.sv */
// Shared types and constants for the multi-tap feedback delay.
// Holds the configuration register map, reset values and the config bundle type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtfd_pkg;

  // fixed field widths
  localparam int DELAY_W = 17;
  localparam int COUNT_W = 4;
  localparam int GAIN_W  = 8;
  localparam int PACK_W  = 64;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;

  // register map, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_DELAY  = 3'd0,
    REG_TAPS   = 3'd1,
    REG_SEND   = 3'd2,
    REG_DRY    = 3'd3,
    REG_WET    = 3'd4,
    REG_FB     = 3'd5,
    REG_TAP_L  = 3'd6,
    REG_TAP_R  = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [DELAY_W-1:0] DELAY_RST = 17'd24000;
  localparam logic [COUNT_W-1:0] TAPS_RST  = 4'd4;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd128;
  localparam logic [PACK_W-1:0]  FB_RST    = 64'h0;
  localparam logic [PACK_W-1:0]  PAN_RST   = 64'h5A5A5A5A5A5A5A5A;

  // configuration seen by the datapath
  typedef struct packed {
    logic [COUNT_W-1:0] tap_count;
    logic [GAIN_W-1:0]  send_gain;
    logic [GAIN_W-1:0]  dry_out_gain;
    logic [GAIN_W-1:0]  wet_out_gain;
    logic [PACK_W-1:0]  feedback_gains;
    logic [PACK_W-1:0]  tap_left_gains;
    logic [PACK_W-1:0]  tap_right_gains;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/multi_tap_feedback_delay_core.sv */
// Stereo multi-tap feedback delay, one stereo frame in and one result item out.
// Instantiates mtfd_regs, mtfd_line_mem and mtfd_engine; depends on mtfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The time one item takes grows with T, the active tap count (zero to MAX_TAPS). It is
// set by the single read port of the delay line memory, which delivers one stereo tap
// per cycle, and by the per-channel multiply-accumulate that walks the taps once for
// feedback and once for the wet sum. A finished item waits in the output register while
// the next one is taken in. Both channels share one memory word per address. Entries
// that were never written read as zero by tracking the fill level, so there is no
// clearing pass after reset. After reset and after every write of delay_samples the
// block takes no item while the tap spacing is reduced modulo the line depth.
module multi_tap_feedback_delay_core import mtfd_pkg::*; #(
  parameter int LINE_DEPTH  = 1048576,
  parameter int MAX_TAPS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [DATA_W-1:0]             pwdata,
  output logic      [DATA_W-1:0]             prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic signed [SAMPLE_BITS-1:0]      wet_left,
  output logic signed [SAMPLE_BITS-1:0]      wet_right
);

  localparam int LA_W = $clog2(LINE_DEPTH);

  cfg_t                     cfg;
  logic [LA_W-1:0]          dly_red;
  logic                     dly_busy;
  logic                     mem_we;
  logic [LA_W-1:0]          mem_waddr;
  logic [2*SAMPLE_BITS-1:0] mem_wdata;
  logic                     mem_re;
  logic [LA_W-1:0]          mem_raddr;
  logic [2*SAMPLE_BITS-1:0] mem_rdata;

  // configuration registers
  mtfd_regs #(
    .LINE_DEPTH (LINE_DEPTH),
    .LA_W       (LA_W)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .dly_red  (dly_red),
    .dly_busy (dly_busy)
  );

  // stereo delay line
  mtfd_line_mem #(
    .DEPTH (LINE_DEPTH),
    .AW    (LA_W),
    .WIDTH (2 * SAMPLE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // item sequencer and datapath
  mtfd_engine #(
    .LINE_DEPTH  (LINE_DEPTH),
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LA_W        (LA_W)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .dly_red   (dly_red),
    .dly_busy  (dly_busy),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_left   (in_left),
    .in_right  (in_right),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right),
    .wet_left  (wet_left),
    .wet_right (wet_right),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire

/* hdl/mtfd_regs.sv */
// Configuration register file with an APB-style port.
// Also reduces the tap spacing modulo the line depth, one subtract per cycle.
// Depends on mtfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtfd_regs import mtfd_pkg::*; #(
  parameter int LINE_DEPTH = 1048576,
  parameter int LA_W       = 20
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg,
  output logic      [LA_W-1:0]   dly_red,
  output logic                   dly_busy
);

  localparam int DM_W = (LA_W > DELAY_W) ? LA_W : DELAY_W;

  logic [DELAY_W-1:0] delay_samples;
  logic [DM_W-1:0]    dly_mod;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples       <= DELAY_RST;
      cfg.tap_count       <= TAPS_RST;
      cfg.send_gain       <= GAIN_RST;
      cfg.dry_out_gain    <= GAIN_RST;
      cfg.wet_out_gain    <= GAIN_RST;
      cfg.feedback_gains  <= FB_RST;
      cfg.tap_left_gains  <= PAN_RST;
      cfg.tap_right_gains <= PAN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DELAY: delay_samples       <= pwdata[DELAY_W-1:0];
        REG_TAPS:  cfg.tap_count       <= pwdata[COUNT_W-1:0];
        REG_SEND:  cfg.send_gain       <= pwdata[GAIN_W-1:0];
        REG_DRY:   cfg.dry_out_gain    <= pwdata[GAIN_W-1:0];
        REG_WET:   cfg.wet_out_gain    <= pwdata[GAIN_W-1:0];
        REG_FB:    cfg.feedback_gains  <= pwdata;
        REG_TAP_L: cfg.tap_left_gains  <= pwdata;
        REG_TAP_R: cfg.tap_right_gains <= pwdata;
        default:   ;
      endcase
    end
  end

  // spacing modulo line depth, reduced by repeated subtraction
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_mod  <= DM_W'(DELAY_RST);
      dly_busy <= 1'b1;
    end else if (wr_en && idx == REG_DELAY) begin
      dly_mod  <= DM_W'(pwdata[DELAY_W-1:0]);
      dly_busy <= 1'b1;
    end else if (dly_busy) begin
      if ({1'b0, dly_mod} >= (DM_W+1)'(LINE_DEPTH)) begin
        dly_mod <= dly_mod - DM_W'(LINE_DEPTH);
      end else begin
        dly_busy <= 1'b0;
      end
    end
  end

  assign dly_red = dly_mod[LA_W-1:0];

  // register readback
  always_comb begin
    case (idx)
      REG_DELAY: prdata = DATA_W'(delay_samples);
      REG_TAPS:  prdata = DATA_W'(cfg.tap_count);
      REG_SEND:  prdata = DATA_W'(cfg.send_gain);
      REG_DRY:   prdata = DATA_W'(cfg.dry_out_gain);
      REG_WET:   prdata = DATA_W'(cfg.wet_out_gain);
      REG_FB:    prdata = cfg.feedback_gains;
      REG_TAP_L: prdata = cfg.tap_left_gains;
      REG_TAP_R: prdata = cfg.tap_right_gains;
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/mtfd_line_mem.sv */
// Stereo delay line storage, one word holds a left and a right sample.
// Simple dual-port memory, registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mtfd_line_mem #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20,
  parameter int WIDTH = 48
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/mtfd_engine.sv */
// Per-item sequencer and datapath: tap reads, feedback write-back, wet and mix.
// Drives the delay line memory and the item handshakes. Depends on mtfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtfd_engine import mtfd_pkg::*; #(
  parameter int LINE_DEPTH  = 1048576,
  parameter int MAX_TAPS    = 8,
  parameter int SAMPLE_BITS = 24,
  parameter int LA_W        = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfg_t                          cfg,
  input  wire logic [LA_W-1:0]               dly_red,
  input  wire logic                          dly_busy,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic signed [SAMPLE_BITS-1:0]      wet_left,
  output logic signed [SAMPLE_BITS-1:0]      wet_right,
  output logic                               mem_we,
  output logic [LA_W-1:0]                    mem_waddr,
  output logic [2*SAMPLE_BITS-1:0]           mem_wdata,
  output logic                               mem_re,
  output logic [LA_W-1:0]                    mem_raddr,
  input  wire logic [2*SAMPLE_BITS-1:0]      mem_rdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int ACC_W  = SB + 13;
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int SLOT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(64);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_WET   = 7'b0001000,
    S_MIX   = 7'b0010000,
    S_MIX2  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // sample times unsigned Q1.7 gain, at accumulator width
  function automatic logic signed [ACC_W-1:0] mulg(input logic signed [SB-1:0] s,
                                                   input logic [GAIN_W-1:0] g);
    logic signed [ACC_W-1:0] se;
    logic signed [ACC_W-1:0] ge;
    se = ACC_W'(s);
    ge = ACC_W'($signed({1'b0, g}));
    return se * ge;
  endfunction

  // round half up from 2^7 scale, then saturate
  function automatic logic signed [SB-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] q;
    t = acc + RND;
    q = t >>> 7;
    if (q > SMAX) return SMAX[SB-1:0];
    else if (q < SMIN) return SMIN[SB-1:0];
    else return q[SB-1:0];
  endfunction

  // one tap spacing further back, modulo line depth
  function automatic logic [LA_W-1:0] step_back(input logic [LA_W-1:0] a,
                                                input logic [LA_W-1:0] d);
    logic [LA_W:0] w;
    w = {1'b0, a} + (LA_W+1)'(LINE_DEPTH) - {1'b0, d};
    if (a >= d) return a - d;
    else return w[LA_W-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] gain_at(input logic [PACK_W-1:0] p,
                                                input logic [SLOT_W-1:0] k);
    return p[k*GAIN_W +: GAIN_W];
  endfunction

  state_t state;

  logic [LA_W-1:0]  wi;
  logic             full;
  logic [LA_W-1:0]  tap_addr;
  logic [TAP_W-1:0] issue_cnt;
  logic [TAP_W-1:0] ret_cnt;
  logic [TAP_W-1:0] wet_cnt;
  logic [TAP_W-1:0] taps;
  logic             issue;

  // read return pipeline
  logic              rd_pending;
  logic              rd_ok;
  logic              rd_same;
  logic [SLOT_W-1:0] rd_slot;

  // per-tap sample store
  logic signed [SB-1:0] tap_l [MAX_TAPS];
  logic signed [SB-1:0] tap_r [MAX_TAPS];
  logic                 same_q [MAX_TAPS];

  logic signed [SB-1:0]    x_l, x_r;
  logic signed [ACC_W-1:0] acc_l, acc_r;
  logic signed [SB-1:0]    new_l, new_r;
  logic signed [ACC_W-1:0] wacc_l, wacc_r;
  logic signed [SB-1:0]    wv_l, wv_r;
  logic signed [ACC_W-1:0] mix_l, mix_r;

  logic signed [SB-1:0] vl, vr;
  logic signed [SB-1:0] fb_l, fb_r;
  logic signed [SB-1:0] wt_l, wt_r;
  logic [SLOT_W-1:0]    ws;

  // active taps, clamped
  always_comb begin
    if (cfg.tap_count > COUNT_W'(MAX_TAPS)) taps = TAP_W'(MAX_TAPS);
    else taps = TAP_W'(cfg.tap_count);
  end

  assign in_stall = (state != S_IDLE) || dly_busy;
  assign issue    = (state == S_READ) && (issue_cnt != taps);

  // memory access
  assign mem_re    = issue;
  assign mem_raddr = tap_addr;
  assign mem_we    = (state == S_WRITE);
  assign mem_waddr = wi;
  assign fb_l      = round_sat(acc_l);
  assign fb_r      = round_sat(acc_r);
  assign mem_wdata = {fb_r, fb_l};

  // returned tap, zero where the line was never written
  assign vl = rd_ok ? $signed(mem_rdata[SB-1:0]) : '0;
  assign vr = rd_ok ? $signed(mem_rdata[2*SB-1:SB]) : '0;

  // wet tap, forwarded from this item's write when the tap lands on it
  assign ws   = wet_cnt[SLOT_W-1:0];
  assign wt_l = same_q[ws] ? new_l : tap_l[ws];
  assign wt_r = same_q[ws] ? new_r : tap_r[ws];

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rd_pending <= 1'b0;
      wi         <= '0;
      full       <= 1'b0;
      issue_cnt  <= '0;
      ret_cnt    <= '0;
      wet_cnt    <= '0;
    end else begin
      rd_pending <= issue;
      // output register load or drain
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            x_l       <= in_left;
            x_r       <= in_right;
            acc_l     <= mulg(in_left, cfg.send_gain);
            acc_r     <= mulg(in_right, cfg.send_gain);
            tap_addr  <= step_back(wi, dly_red);
            issue_cnt <= '0;
            ret_cnt   <= '0;
            state     <= S_READ;
          end
        end
        S_READ: begin
          if (issue) begin
            tap_addr  <= step_back(tap_addr, dly_red);
            issue_cnt <= issue_cnt + TAP_W'(1);
            rd_ok     <= full || (tap_addr < wi);
            rd_same   <= (tap_addr == wi);
            rd_slot   <= issue_cnt[SLOT_W-1:0];
          end
          if (rd_pending) begin
            tap_l[rd_slot]  <= vl;
            tap_r[rd_slot]  <= vr;
            same_q[rd_slot] <= rd_same;
            acc_l   <= acc_l + mulg(vl, gain_at(cfg.feedback_gains, rd_slot));
            acc_r   <= acc_r + mulg(vr, gain_at(cfg.feedback_gains, rd_slot));
            ret_cnt <= ret_cnt + TAP_W'(1);
          end else if (ret_cnt == taps) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          new_l   <= fb_l;
          new_r   <= fb_r;
          wacc_l  <= '0;
          wacc_r  <= '0;
          wet_cnt <= '0;
          state   <= S_WET;
        end
        S_WET: begin
          if (wet_cnt != taps) begin
            wacc_l  <= wacc_l + mulg(wt_l, gain_at(cfg.tap_left_gains, ws));
            wacc_r  <= wacc_r + mulg(wt_r, gain_at(cfg.tap_right_gains, ws));
            wet_cnt <= wet_cnt + TAP_W'(1);
          end else begin
            state <= S_MIX;
          end
        end
        S_MIX: begin
          wv_l  <= round_sat(wacc_l);
          wv_r  <= round_sat(wacc_r);
          state <= S_MIX2;
        end
        S_MIX2: begin
          mix_l <= mulg(x_l, cfg.dry_out_gain) + mulg(wv_l, cfg.wet_out_gain);
          mix_r <= mulg(x_r, cfg.dry_out_gain) + mulg(wv_r, cfg.wet_out_gain);
          state <= S_DONE;
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid || !out_stall) begin
            out_left  <= round_sat(mix_l);
            out_right <= round_sat(mix_r);
            wet_left  <= wv_l;
            wet_right <= wv_r;
            if (wi == LA_W'(LINE_DEPTH - 1)) begin
              wi   <= '0;
              full <= 1'b1;
            end else begin
              wi <= wi + LA_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for multi_tap_feedback_delay_core: directed rows, then random phases.
// Predicts each stereo result from a behavioral copy of both delay lines; directed rows may give theirs.
// Depends on mtfd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import mtfd_pkg::*;

  localparam int LINE_DEPTH = 1048576;
  localparam int MAX_TAPS   = 8;
  localparam int SETTLE_CYC = 32;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 50;
  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = 24'sh800000;

  typedef struct {
    logic signed [23:0] out_l;
    logic signed [23:0] out_r;
    logic signed [23:0] wet_l;
    logic signed [23:0] wet_r;
  } frame_res_t;

  typedef struct {
    bit                 is_cfg;
    reg_idx_t           idx;
    logic [63:0]        val;
    logic signed [23:0] l;
    logic signed [23:0] r;
    bit                 known;
    frame_res_t         res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [23:0] in_left = '0;
  logic signed [23:0] in_right = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [23:0] out_left;
  logic signed [23:0] out_right;
  logic signed [23:0] wet_left;
  logic signed [23:0] wet_right;

  // shadow configuration and delay lines (left at 0, right at LINE_DEPTH)
  int unsigned cfg_delay = DELAY_RST;
  int unsigned cfg_taps  = TAPS_RST;
  int unsigned cfg_send  = GAIN_RST;
  int unsigned cfg_dry   = GAIN_RST;
  int unsigned cfg_wet   = GAIN_RST;
  logic [63:0] cfg_fb    = FB_RST;
  logic [63:0] cfg_pan_l = PAN_RST;
  logic [63:0] cfg_pan_r = PAN_RST;
  int          line_mem [0:2*LINE_DEPTH-1];
  int unsigned wr_pos = 0;

  frame_res_t  pending_mix[$];
  stim_row_t   stim_rows[$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;

  multi_tap_feedback_delay_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_left(in_left), .in_right(in_right),
    .out_valid(out_valid), .out_stall(out_stall), .out_left(out_left),
    .out_right(out_right), .wet_left(wet_left), .wet_right(wet_right)
  );

  always #6 clk = ~clk;

  // run limit, far above the slowest correct run
  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // round half up from 2^7 scale, then clamp to the sample range
  function automatic longint round_clamp(longint acc);
    longint q;
    q = (acc + 64) >>> 7;
    if (q > 64'sd8388607) q = 64'sd8388607;
    else if (q < -64'sd8388608) q = -64'sd8388608;
    return q;
  endfunction

  function automatic longint gain_of(logic [63:0] gains, int t);
    return longint'((gains >> (8 * (t - 1))) & 64'hFF);
  endfunction

  function automatic int tap_addr(int t);
    longint offs;
    offs = (longint'(t) * longint'(cfg_delay)) % LINE_DEPTH;
    return int'((longint'(wr_pos) + LINE_DEPTH - offs) % LINE_DEPTH);
  endfunction

  // one channel: feedback write into the line, then the wet sum read after it
  function automatic void mix_channel(int base, longint x, logic [63:0] pan,
                                      output longint wet, output longint mix);
    longint acc;
    longint wacc;
    int     taps;
    taps = (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
    acc  = x * longint'(cfg_send);
    wacc = 0;
    for (int t = 1; t <= taps; t++)
      acc += longint'(line_mem[base + tap_addr(t)]) * gain_of(cfg_fb, t);
    line_mem[base + wr_pos] = int'(round_clamp(acc));
    for (int t = 1; t <= taps; t++)
      wacc += longint'(line_mem[base + tap_addr(t)]) * gain_of(pan, t);
    wet = round_clamp(wacc);
    mix = round_clamp(x * longint'(cfg_dry) + wet * longint'(cfg_wet));
  endfunction

  function automatic frame_res_t predict_frame(logic signed [23:0] l, logic signed [23:0] r);
    frame_res_t res;
    longint     wl, wr, ml, mr;
    mix_channel(0, longint'(l), cfg_pan_l, wl, ml);
    mix_channel(LINE_DEPTH, longint'(r), cfg_pan_r, wr, mr);
    wr_pos = (wr_pos + 1) % LINE_DEPTH;
    res.out_l = ml[23:0];
    res.out_r = mr[23:0];
    res.wet_l = wl[23:0];
    res.wet_r = wr[23:0];
    return res;
  endfunction

  // update the shadow register, return what a read should give back
  function automatic logic [63:0] apply_reg(reg_idx_t idx, logic [63:0] v);
    case (idx)
      REG_DELAY: begin
        cfg_delay = v[DELAY_W-1:0];
        return {47'b0, v[DELAY_W-1:0]};
      end
      REG_TAPS: begin
        cfg_taps = v[COUNT_W-1:0];
        return {60'b0, v[COUNT_W-1:0]};
      end
      REG_SEND: begin
        cfg_send = v[7:0];
        return {56'b0, v[7:0]};
      end
      REG_DRY: begin
        cfg_dry = v[7:0];
        return {56'b0, v[7:0]};
      end
      REG_WET: begin
        cfg_wet = v[7:0];
        return {56'b0, v[7:0]};
      end
      REG_FB: cfg_fb = v;
      REG_TAP_L: cfg_pan_l = v;
      default: cfg_pan_r = v;
    endcase
    return v;
  endfunction

  // a setup then an access phase; entered and left right after a falling edge
  task automatic apb_xfer(input bit wr, input reg_idx_t idx, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    logic [63:0] want;
    logic [63:0] got;
    want = apply_reg(idx, v);
    apb_xfer(1'b1, idx, v, got);
    apb_xfer(1'b0, idx, '0, got);
    if (got !== want)
      note_error($sformatf("register %s readback: expected %h, got %h", idx.name(), want, got));
  endtask

  // send one frame; the prediction is taken at the accepting edge
  task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                            input bit known, input frame_res_t given);
    int         gap;
    frame_res_t res;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_left  <= l;
    in_right <= r;
    do @(posedge clk); while (in_stall);
    res = predict_frame(l, r);
    pending_mix.insert(pending_mix.size(), known ? given : res);
    @(negedge clk);
  endtask

  // drop valid and wait until every result is in and the core has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_mix.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic void add_row(stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_t idx, logic [63:0] v);
    stim_row_t row;
    row = '{idx: REG_DELAY, default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = v;
    return row;
  endfunction

  function automatic stim_row_t item_row(logic signed [23:0] l, logic signed [23:0] r);
    stim_row_t row;
    row = '{idx: REG_DELAY, default: '0};
    row.l = l;
    row.r = r;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic signed [23:0] l, logic signed [23:0] r,
                                          logic signed [23:0] ol, logic signed [23:0] orr,
                                          logic signed [23:0] wl, logic signed [23:0] wr);
    stim_row_t row;
    row = item_row(l, r);
    row.known = 1'b1;
    row.res.out_l = ol;
    row.res.out_r = orr;
    row.res.wet_l = wl;
    row.res.wet_r = wr;
    return row;
  endfunction

  function automatic logic signed [23:0] draw_sample();
    int s;
    case ($urandom_range(0, 5))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: begin
        s = int'($urandom_range(0, 4095)) - 2048;
        return s[23:0];
      end
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] draw_feedback();
    logic [63:0] g;
    int          m;
    g = '0;
    m = $urandom_range(0, 3);
    for (int b = 0; b < 8; b++) begin
      case (m)
        0: g[8*b +: 8] = 8'd0;
        1, 2: g[8*b +: 8] = 8'($urandom_range(0, 40));
        default: g[8*b +: 8] = 8'($urandom);
      endcase
    end
    return g;
  endfunction

  function automatic logic [63:0] draw_delay();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'd131071;
      2: return 64'($urandom_range(1, 131071));
      default: return 64'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [63:0] draw_taps();
    if ($urandom_range(0, 7) == 0) return 64'($urandom_range(0, 15));
    return 64'($urandom_range(1, MAX_TAPS));
  endfunction

  // result side: random stall before each item, then compare with the oldest prediction
  initial begin
    int         k;
    frame_res_t want;
    while (rst) @(negedge clk);
    forever begin
      k = draw_wait();
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (pending_mix.size() == 0) begin
        note_error($sformatf("unexpected item: out %0d/%0d wet %0d/%0d",
                             out_left, out_right, wet_left, wet_right));
      end else begin
        want = pending_mix.pop_front();
        if (out_left !== want.out_l || out_right !== want.out_r ||
            wet_left !== want.wet_l || wet_right !== want.wet_r)
          note_error($sformatf({"mix mismatch: expected out %0d/%0d wet %0d/%0d, ",
                                "got out %0d/%0d wet %0d/%0d"},
                               want.out_l, want.out_r, want.wet_l, want.wet_r,
                               out_left, out_right, wet_left, wet_right));
      end
      @(negedge clk);
    end
  end

  // stimulus: directed rows first, then random configuration phases
  initial begin
    bit         busy;
    frame_res_t none;
    none = '{default: '0};
    busy = 1'b0;

    // reset defaults: taps read empty lines, so out follows in and wet is zero
    add_row(known_row(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    add_row(known_row(S_MAX, S_MIN, S_MAX, S_MIN, 24'sd0, 24'sd0));
    add_row(known_row(S_MIN, S_MAX, S_MIN, S_MAX, 24'sd0, 24'sd0));
    add_row(known_row(-24'sd1, 24'sd1, -24'sd1, 24'sd1, 24'sd0, 24'sd0));
    add_row(known_row(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'sd0, 24'sd0));
    add_row(known_row(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'sd0, 24'sd0));
    // all gains but the right taps at maximum, tightest spacing: drives the sums into saturation
    add_row(cfg_row(REG_DELAY, 64'd1));
    add_row(cfg_row(REG_TAPS, 64'd8));
    add_row(cfg_row(REG_SEND, 64'd255));
    add_row(cfg_row(REG_DRY, 64'd255));
    add_row(cfg_row(REG_WET, 64'd255));
    add_row(cfg_row(REG_FB, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(cfg_row(REG_TAP_L, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(cfg_row(REG_TAP_R, 64'h0));
    add_row(item_row(S_MAX, S_MIN));
    add_row(item_row(S_MAX, S_MIN));
    add_row(item_row(S_MIN, S_MAX));
    // no taps active: wet is zero and out is the clamped dry path
    add_row(cfg_row(REG_TAPS, 64'd0));
    add_row(known_row(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    add_row(known_row(S_MAX, S_MIN, S_MAX, S_MIN, 24'sd0, 24'sd0));
    // tap count above the maximum is clamped to eight
    add_row(cfg_row(REG_TAPS, 64'd15));
    add_row(item_row(24'sd1000, -24'sd1000));
    add_row(item_row(S_MIN, S_MAX));
    // zero spacing: feedback sees the old sample, wet sees the new one
    add_row(cfg_row(REG_DELAY, 64'd0));
    add_row(cfg_row(REG_TAPS, 64'd3));
    add_row(item_row(24'sd12345, -24'sd54321));
    add_row(item_row(-24'sd7, 24'sd7));
    // widest spacing reaches back into never-written entries
    add_row(cfg_row(REG_DELAY, 64'd131071));
    add_row(cfg_row(REG_TAPS, 64'd8));
    add_row(item_row(S_MAX, S_MAX));
    add_row(item_row(S_MIN, S_MIN));
    // all scalar gains off, line content still feeds the wet sum
    add_row(cfg_row(REG_DELAY, 64'd2));
    add_row(cfg_row(REG_SEND, 64'd0));
    add_row(cfg_row(REG_DRY, 64'd0));
    add_row(cfg_row(REG_WET, 64'd0));
    add_row(item_row(S_MAX, S_MIN));
    add_row(item_row(24'sd5, -24'sd5));

    // reset, released on a falling edge
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        if (busy) settle();
        busy = 1'b0;
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        busy = 1'b1;
        send_frame(stim_rows[i].l, stim_rows[i].r, stim_rows[i].known, stim_rows[i].res);
      end
    end

    // random phases, each with a fresh configuration
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      no_idle = 1'b0;
      write_reg(REG_DELAY, draw_delay());
      write_reg(REG_TAPS, draw_taps());
      write_reg(REG_SEND, 64'($urandom_range(0, 255)));
      write_reg(REG_DRY, 64'($urandom_range(0, 255)));
      write_reg(REG_WET, 64'($urandom_range(0, 255)));
      write_reg(REG_FB, draw_feedback());
      write_reg(REG_TAP_L, {$urandom, $urandom});
      write_reg(REG_TAP_R, {$urandom, $urandom});
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_LEN; n++)
        send_frame(draw_sample(), draw_sample(), 1'b0, none);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
